// ===== src/rws_pkg.sv =====
`default_nettype none

package rws_pkg;

  // Frame geometry defaults
  localparam int DEF_FRAME_WIDTH  = 32;
  localparam int DEF_FRAME_HEIGHT = 24;

  // Field widths
  localparam int TEMP_W     = 16;
  localparam int VAR_W      = 30;
  localparam int LEFT_W     = 5;
  localparam int TOP_W      = 5;
  localparam int WIDTH_W    = 6;
  localparam int HEIGHT_W   = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = TEMP_W;
  localparam int OUT_DATA_W = ((3 * TEMP_W + VAR_W + 7) / 8) * 8;

  // Position compare width: covers frame coordinates up to 1023 and left + width
  localparam int POS_W = 10;

  // Largest region extent the window registers can describe
  localparam int WIN_COLS_MAX = (1 << WIDTH_W) - 1;
  localparam int WIN_ROWS_MAX = (1 << HEIGHT_W) - 1;

  localparam logic [VAR_W-1:0] VAR_LIMIT = 30'd1073676289;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [LEFT_W-1:0]   RST_LEFT   = 5'd3;
  localparam logic [TOP_W-1:0]    RST_TOP    = 5'd5;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 6'd4;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 5'd4;

  typedef struct packed {
    logic acc_clear;
    logic mul_en;
    logic sum_en;
    logic sub_en;
    logic div_start;
    logic div_var;
    logic mean_cap;
    logic var_cap;
    logic out_load;
  } rws_cmd_t;

  typedef struct packed {
    logic last_acc;
    logic div_done;
    logic out_free;
  } rws_sts_t;

endpackage

`default_nettype wire

// ===== src/rws_div.sv =====
`default_nettype none

module rws_div #(
  parameter int DVD_W = 50,
  parameter int DVS_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o,
  output logic [DVS_W-1:0]      remainder_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;
  logic [DVS_W-1:0] rem_d;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
    rem_d = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== src/rws_datapath.sv =====
`default_nettype none

module rws_datapath #(
  parameter int FRAME_WIDTH  = rws_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = rws_pkg::DEF_FRAME_HEIGHT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rws_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  input  wire logic [rws_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  wire logic                                s_axis_tlast_i,
  input  wire logic                                in_ready_i,
  input  wire logic                                m_axis_tready_i,
  output logic                                     m_axis_tvalid_o,
  output logic [rws_pkg::OUT_DATA_W-1:0]           m_axis_tdata_o,
  input  wire rws_pkg::rws_cmd_t                   cmd_i,
  output rws_pkg::rws_sts_t                        sts_o
);

  localparam int TW    = rws_pkg::TEMP_W;
  localparam int PW    = rws_pkg::POS_W;
  localparam int CW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int RW    = $clog2(FRAME_HEIGHT + 1);
  localparam int NCOL  = (FRAME_WIDTH < rws_pkg::WIN_COLS_MAX) ?
                         FRAME_WIDTH : rws_pkg::WIN_COLS_MAX;
  localparam int NROW  = (FRAME_HEIGHT < rws_pkg::WIN_ROWS_MAX) ?
                         FRAME_HEIGHT : rws_pkg::WIN_ROWS_MAX;
  localparam int NMAX  = NCOL * NROW;
  localparam int NW    = $clog2(NMAX + 1);
  localparam int SW    = TW + NW;
  localparam int AW    = SW - 1;
  localparam int PSQ_W = 2 * TW - 1;
  localparam int QW    = 2 * TW - 2 + NW;
  localparam int QL    = QW / 2;
  localparam int QH    = QW - QL;
  localparam int DW    = QW + NW;
  localparam int VW    = 2 * NW;

  // Configuration
  logic [rws_pkg::LEFT_W-1:0]   left_q;
  logic [rws_pkg::TOP_W-1:0]    top_q;
  logic [rws_pkg::WIDTH_W-1:0]  width_q;
  logic [rws_pkg::HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= rws_pkg::RST_LEFT;
      top_q    <= rws_pkg::RST_TOP;
      width_q  <= rws_pkg::RST_WIDTH;
      height_q <= rws_pkg::RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rws_pkg::REG_LEFT:   left_q   <= cfg_wdata_i[rws_pkg::LEFT_W-1:0];
        rws_pkg::REG_TOP:    top_q    <= cfg_wdata_i[rws_pkg::TOP_W-1:0];
        rws_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[rws_pkg::WIDTH_W-1:0];
        rws_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[rws_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position
  logic          accept;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          in_frame;
  logic          in_win;
  logic [PW-1:0] col_p;
  logic [PW-1:0] row_p;

  assign accept = s_axis_tvalid_i & in_ready_i;

  always_comb begin
    col_p    = PW'(col_q);
    row_p    = PW'(row_q);
    in_frame = (row_q < RW'(FRAME_HEIGHT));
    in_win   = in_frame &&
               (col_p >= PW'(left_q)) && (col_p < PW'(left_q) + PW'(width_q)) &&
               (row_p >= PW'(top_q))  && (row_p < PW'(top_q) + PW'(height_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (in_frame) begin
        if (({1'b0, col_q} + 1'b1) >= (CW + 1)'(FRAME_WIDTH)) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Square stage
  logic signed [2*TW-1:0] prod;
  logic signed [TW-1:0]   t_q;
  logic [PSQ_W-1:0]       psq_q;
  logic                   acc_en_q;

  assign prod = $signed(s_axis_tdata_i) * $signed(s_axis_tdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= accept & in_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q   <= $signed(s_axis_tdata_i);
      psq_q <= prod[PSQ_W-1:0];
    end
  end

  // Accumulators
  logic signed [SW-1:0] sum_q;
  logic [QW-1:0]        sqsum_q;
  logic signed [TW-1:0] max_q;
  logic signed [TW-1:0] min_q;
  logic [NW-1:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      max_q   <= rws_pkg::TEMP_MIN;
      min_q   <= rws_pkg::TEMP_MAX;
      cnt_q   <= '0;
    end else if (cmd_i.acc_clear) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      max_q   <= rws_pkg::TEMP_MIN;
      min_q   <= rws_pkg::TEMP_MAX;
      cnt_q   <= '0;
    end else if (acc_en_q) begin
      sum_q   <= sum_q + SW'(t_q);
      sqsum_q <= sqsum_q + QW'(psq_q);
      if (t_q > max_q) max_q <= t_q;
      if (t_q < min_q) min_q <= t_q;
      cnt_q   <= cnt_q + 1'b1;
    end
  end

  // Frame-end arithmetic
  logic                  neg_q;
  logic [AW-1:0]         abs_q;
  logic [NW+QL-1:0]      nql_q;
  logic [NW+QH-1:0]      nqh_q;
  logic [VW-1:0]         nn_q;
  logic [DW-1:0]         nq_q;
  logic [DW-1:0]         sqr_q;
  logic [DW-1:0]         num_q;
  logic [SW-1:0]         abs_full;
  logic [NW+QL-1:0]      nql_d;
  logic [NW+QH-1:0]      nqh_d;
  logic [VW-1:0]         nn_d;
  logic [DW-1:0]         sqr_d;

  always_comb begin
    abs_full = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
    nql_d    = (NW + QL)'(cnt_q) * (NW + QL)'(sqsum_q[QL-1:0]);
    nqh_d    = (NW + QH)'(cnt_q) * (NW + QH)'(sqsum_q[QW-1:QL]);
    nn_d     = VW'(cnt_q) * VW'(cnt_q - 1'b1);
    sqr_d    = abs_q * abs_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      neg_q <= sum_q[SW-1];
      abs_q <= abs_full[AW-1:0];
      nql_q <= nql_d;
      nqh_q <= nqh_d;
      nn_q  <= nn_d;
    end
    if (cmd_i.sum_en) begin
      nq_q  <= (DW'(nqh_q) << QL) + DW'(nql_q);
      sqr_q <= sqr_d;
    end
    if (cmd_i.sub_en) begin
      num_q <= nq_q - sqr_q;
    end
  end

  // Shared divider
  logic [DW-1:0] div_quo;
  logic [VW-1:0] div_rem;
  logic          div_done;

  rws_div #(
    .DVD_W (DW),
    .DVS_W (VW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (cmd_i.div_var ? num_q : DW'(abs_q)),
    .divisor_i   (cmd_i.div_var ? nn_q : VW'(cnt_q)),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  logic [TW-1:0]             mean_mag;
  logic [TW-1:0]             mean_q;
  logic [rws_pkg::VAR_W-1:0] var_q;

  // round the magnitude up only for a negative sum, so the mean floors
  assign mean_mag = div_quo[TW-1:0] + TW'(neg_q & (|div_rem));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_cap) begin
      mean_q <= neg_q ? (~mean_mag + 1'b1) : mean_mag;
    end
    if (cmd_i.var_cap) begin
      var_q <= (div_quo > DW'(rws_pkg::VAR_LIMIT)) ? rws_pkg::VAR_LIMIT :
               div_quo[rws_pkg::VAR_W-1:0];
    end
  end

  // Output register
  logic                      out_valid_q;
  logic [TW-1:0]             out_max_q;
  logic [TW-1:0]             out_min_q;
  logic [TW-1:0]             out_mean_q;
  logic [rws_pkg::VAR_W-1:0] out_var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cnt_q == '0) begin
        out_max_q  <= '0;
        out_min_q  <= '0;
        out_mean_q <= '0;
        out_var_q  <= '0;
      end else begin
        out_max_q  <= max_q;
        out_min_q  <= min_q;
        out_mean_q <= mean_q;
        out_var_q  <= (cnt_q > NW'(1)) ? var_q : '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = rws_pkg::OUT_DATA_W'({out_var_q, out_mean_q, out_min_q, out_max_q});

  always_comb begin
    sts_o.last_acc = accept & s_axis_tlast_i;
    sts_o.div_done = div_done;
    sts_o.out_free = ~out_valid_q | m_axis_tready_i;
  end

`ifndef NO_ASSERTIONS
  a_acc_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_en_q |-> $past(accept))
    else $error("accumulate without an accepted pixel");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(NMAX))
    else $error("pixel count exceeds region bound");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwritten before transaction");
`endif

endmodule

`default_nettype wire

// ===== src/rws_ctrl.sv =====
`default_nettype none

module rws_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rws_pkg::rws_sts_t sts_i,
  output rws_pkg::rws_cmd_t      cmd_o,
  output logic                   in_ready_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DRAIN  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_SUB    = 4'd4;
  localparam logic [3:0] S_MSTART = 4'd5;
  localparam logic [3:0] S_MWAIT  = 4'd6;
  localparam logic [3:0] S_VSTART = 4'd7;
  localparam logic [3:0] S_VWAIT  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (sts_i.last_acc) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_MUL;
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub_en = 1'b1;
        state_d      = S_MSTART;
      end
      S_MSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_cap = 1'b1;
          state_d        = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_var   = 1'b1;
        state_d         = S_VWAIT;
      end
      S_VWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.var_cap = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.acc_clear = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.last_acc |=> (state_q == S_DRAIN))
    else $error("frame end not followed by drain");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_MWAIT || state_q == S_VWAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

// ===== src/roi_window_statistics.sv =====
// Region-of-interest statistics over a raster stream of thermal pixels.
// Slave stream: one signed 1/64 degree pixel per transaction in tdata[15:0],
// tlast marks the last pixel of a frame. Column and row are counted inside.
// Master stream: one result per frame, tdata holds max, min, floor mean and
// sample variance (n-1 divisor, saturated).
// Configuration: write enable, register index (0 left, 1 top, 2 width,
// 3 height) and data, taken at any edge with the enable high; write only
// while the block is idle.
// Throughput: one pixel per cycle within a frame. After the tlast pixel the
// slave side drops tready while the bit-serial divider runs once for the
// mean and once for the variance, on dividends of DW = 30 + 2*NW bits, NW
// the width of the pixel counter (NW = 10 at the default 32x24 frame).
// The result becomes valid after the variance division, once the output
// register is free, and tready returns with it.
// A stalled master side holds the result in the output register; pixels of
// the next frame keep flowing and only the next frame end waits for it.
// Reset: registers return to left 3, top 5, width 4, height 4; counters and
// accumulators clear, no result is pending.
`default_nettype none

module roi_window_statistics #(
  parameter int FRAME_WIDTH  = rws_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = rws_pkg::DEF_FRAME_HEIGHT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rws_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] pixel_temp
  input  wire logic [rws_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                           s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [15:0] region_max, [31:16] region_min, [47:32] region_mean,
  // [77:48] region_variance, [79:78] zero
  output logic [rws_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  rws_pkg::rws_cmd_t cmd;
  rws_pkg::rws_sts_t sts;

  rws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o)
  );

  rws_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .in_ready_i      (s_axis_tready_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_roi_window_statistics.sv =====
`timescale 1ns / 100ps

module tb_roi_window_statistics;
  import rws_pkg::*;

  localparam int FW             = DEF_FRAME_WIDTH;
  localparam int FH             = DEF_FRAME_HEIGHT;
  localparam int RESULT_LATENCY = 120;
  localparam int CYCLE_LIMIT    = 3000000;
  localparam int ITEM_TARGET    = 1900;
  localparam int RESULT_TARGET  = 40;

  typedef enum int {
    TEMP_NOISE,
    TEMP_SCENE,
    TEMP_EXTREME
  } temp_style_e;

  typedef struct {
    logic signed [TEMP_W-1:0] peak_hi;
    logic signed [TEMP_W-1:0] peak_lo;
    logic signed [TEMP_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
  } roi_stats_t;

  class roi_stats_scoreboard;
    logic [LEFT_W-1:0]   win_left;
    logic [TOP_W-1:0]    win_top;
    logic [WIDTH_W-1:0]  win_width;
    logic [HEIGHT_W-1:0] win_height;
    int                  col_pos;
    int                  row_pos;
    longint              temp_sum;
    longint unsigned     square_sum;
    int                  temp_hi;
    int                  temp_lo;
    int                  hits;
    roi_stats_t          stats_q[$];
    int                  mismatches;
    int                  results_seen;

    function new();
      win_left     = RST_LEFT;
      win_top      = RST_TOP;
      win_width    = RST_WIDTH;
      win_height   = RST_HEIGHT;
      mismatches   = 0;
      results_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col_pos    = 0;
      row_pos    = 0;
      temp_sum   = 0;
      square_sum = 0;
      temp_hi    = -32768;
      temp_lo    = 32767;
      hits       = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LEFT:   win_left   = val[LEFT_W-1:0];
        REG_TOP:    win_top    = val[TOP_W-1:0];
        REG_WIDTH:  win_width  = val[WIDTH_W-1:0];
        REG_HEIGHT: win_height = val[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [TEMP_W-1:0] raw, logic last);
      int              t;
      longint          m;
      longint unsigned un;
      longint unsigned mag;
      longint unsigned quo;
      roi_stats_t      s;
      t = int'($signed(raw));
      if (col_pos < FW && row_pos < FH &&
          col_pos >= int'(win_left) && col_pos < int'(win_left) + int'(win_width) &&
          row_pos >= int'(win_top) && row_pos < int'(win_top) + int'(win_height)) begin
        temp_sum   += t;
        square_sum += longint'(t) * longint'(t);
        if (t > temp_hi) temp_hi = t;
        if (t < temp_lo) temp_lo = t;
        hits++;
      end
      if (row_pos < FH) begin
        if (col_pos + 1 >= FW) begin
          col_pos = 0;
          row_pos++;
        end else begin
          col_pos++;
        end
      end
      if (!last) return;
      s.peak_hi  = '0;
      s.peak_lo  = '0;
      s.mean     = '0;
      s.variance = '0;
      if (hits > 0) begin
        if (temp_sum >= 0) m = temp_sum / hits;
        else m = -((-temp_sum + hits - 1) / hits);
        s.peak_hi = temp_hi[TEMP_W-1:0];
        s.peak_lo = temp_lo[TEMP_W-1:0];
        s.mean    = m[TEMP_W-1:0];
        if (hits > 1) begin
          un  = hits;
          mag = (temp_sum < 0) ? -temp_sum : temp_sum;
          quo = (un * square_sum - mag * mag) / (un * (un - 1));
          s.variance = (quo > VAR_LIMIT) ? VAR_LIMIT : quo[VAR_W-1:0];
        end
      end
      stats_q.push_back(s);
      clear_frame();
    endfunction

    function void flag(string what, longint want, longint got);
      if (mismatches < 10)
        $display("MISMATCH result %0d %s: expected %0d, got %0d",
                 results_seen, what, want, got);
      mismatches++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      roi_stats_t want;
      roi_stats_t got;
      got.peak_hi  = data[15:0];
      got.peak_lo  = data[31:16];
      got.mean     = data[47:32];
      got.variance = data[77:48];
      results_seen++;
      if (stats_q.size() == 0) begin
        flag("unexpected transaction, max", 0, got.peak_hi);
        return;
      end
      want = stats_q.pop_front();
      if (got.peak_hi !== want.peak_hi) flag("region_max", want.peak_hi, got.peak_hi);
      if (got.peak_lo !== want.peak_lo) flag("region_min", want.peak_lo, got.peak_lo);
      if (got.mean !== want.mean) flag("region_mean", want.mean, got.mean);
      if (got.variance !== want.variance)
        flag("region_variance", want.variance, got.variance);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // [15:0] pixel_temp
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [15:0] region_max, [31:16] region_min, [47:32] region_mean,
  // [77:48] region_variance, [79:78] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  roi_stats_scoreboard sb;
  bit                  idle_on;
  int                  items_sent;
  int                  rx_hold_left;
  int                  cycle_count;

  roi_window_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  initial begin
    int rx_stall_left;
    rx_stall_left   = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        rx_stall_left = pick_gap();
      end
    end
  end

  task automatic send_pixel(input logic [TEMP_W-1:0] temp, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= temp;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pixel(temp, last);
    items_sent++;
  endtask

  task automatic send_frame(input int len, input temp_style_e style);
    int                base;
    int                r;
    logic [TEMP_W-1:0] t;
    base = int'($urandom_range(6000)) - 2000;
    for (int i = 0; i < len; i++) begin
      case (style)
        TEMP_NOISE: t = TEMP_W'($urandom);
        TEMP_SCENE: t = TEMP_W'(base + int'($urandom_range(128)) - 64);
        default: begin
          r = $urandom_range(3);
          t = (r == 0) ? TEMP_MIN : (r == 1) ? TEMP_MAX : TEMP_W'($urandom);
        end
      endcase
      send_pixel(t, i == len - 1);
    end
  endtask

  // hold the sender until every frame result has left the block
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.stats_q.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] win_l, input logic [CFG_DATA_W-1:0] win_t,
                            input logic [CFG_DATA_W-1:0] win_w, input logic [CFG_DATA_W-1:0] win_h);
    logic [CFG_ADDR_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{REG_LEFT, REG_TOP, REG_WIDTH, REG_HEIGHT};
    val = '{win_l, win_t, win_w, win_h};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                    phase;
    int                    frames;
    int                    len;
    int                    span;
    int                    row_end;
    logic [CFG_DATA_W-1:0] wl;
    logic [CFG_DATA_W-1:0] wt;
    logic [CFG_DATA_W-1:0] ww;
    logic [CFG_DATA_W-1:0] wh;

    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    idle_on         = 1'b1;
    items_sent      = 0;
    rx_hold_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty region under the reset window
    send_pixel(TEMP_MAX, 1'b1);
    drain_results();
    set_window(0, 0, 1, 1);
    send_pixel(TEMP_MIN, 1'b1);
    drain_results();
    set_window(0, 0, 4, 1);
    send_pixel(TEMP_MAX, 1'b0);
    send_pixel(TEMP_MIN, 1'b1);
    send_pixel(-16'sd3, 1'b0);
    send_pixel(-16'sd2, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b1);
    for (int i = 0; i < 5; i++) send_pixel(16'd100 + i[15:0], i == 4);

    phase = 0;
    while ((items_sent < ITEM_TARGET || sb.results_seen < RESULT_TARGET || phase < 8) &&
           phase < 80) begin
      drain_results();
      case (phase)
        0:       begin wl = 0;  wt = 0;  ww = 63; wh = 31; end
        1:       begin wl = 31; wt = 3;  ww = 1;  wh = 1;  end
        2:       begin wl = 0;  wt = 0;  ww = 0;  wh = 24; end
        3:       begin wl = 63; wt = 31; ww = 63; wh = 31; end
        4:       begin wl = 20; wt = 1;  ww = 63; wh = 31; end
        5:       begin wl = 0;  wt = 0;  ww = 8;  wh = 2;  end
        6:       begin wl = 10; wt = 0;  ww = 5;  wh = 0;  end
        default: begin
          wl = CFG_DATA_W'($urandom_range(63));
          wt = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(63)) :
                                          CFG_DATA_W'($urandom_range(3));
          ww = CFG_DATA_W'($urandom_range(63));
          wh = CFG_DATA_W'($urandom_range(63));
        end
      endcase
      set_window(wl, wt, ww, wh);
      idle_on = (phase == 0) ? 1'b0 : ($urandom_range(3) != 0);
      frames  = (phase == 0) ? 1 : $urandom_range(6, 3);
      if (int'(wt & 6'h1F) >= FH) begin
        span = FW;
      end else begin
        row_end = int'(wt & 6'h1F) + int'(wh & 6'h1F);
        span    = ((row_end > FH) ? FH : row_end) * FW;
        if (span < 1) span = FW;
      end
      if (span > 4 * FW) span = 4 * FW;
      // stall the result side while short frames keep coming
      if (phase == 5) begin
        rx_hold_left = 2500;
        frames       = 10;
      end
      for (int f = 0; f < frames; f++) begin
        if (phase == 5) len = $urandom_range(16, 1);
        else if (phase == 0) len = FW * FH + $urandom_range(16, 1);
        else len = $urandom_range(span, 1);
        send_frame(len, temp_style_e'($urandom_range(2)));
      end
      phase++;
    end
    drain_results();

    if (sb.mismatches == 0 && sb.stats_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
